FILE: rtl/core/mie_pkg.sv
// Shared types and constants for the modular inverse block.
// Depends on nothing. Used by mie_divider and modular_inverse_euclid.
`timescale 1ns / 1ps

package mie_pkg;

  // Field widths of the item payloads
  localparam int unsigned ModWidth = 63;
  localparam int unsigned ExpWidth = 32;

  // Dividend width of the shared divider: it covers the exponent and the modulus
  localparam int unsigned DivWidth = (ModWidth > ExpWidth) ? ModWidth : ExpWidth;

  // Bit-step counter width (it must be able to hold DivWidth itself)
  localparam int unsigned CntWidth = $clog2(DivWidth + 1);

  // Input item
  typedef struct packed {
    logic [ExpWidth-1:0] exponent;
    logic [ModWidth-1:0] modulus;
  } mie_in_t;

  // Result item
  typedef struct packed {
    logic [ModWidth-1:0] inverse;
    logic                no_inverse;
  } mie_out_t;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/mie_divider.sv
// Shared restoring divider that produces one quotient bit per cycle. It also
// accumulates quotient * mult in Horner form. Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_divider import mie_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivWidth-1:0] dividend_i,
  input  logic [ModWidth-1:0] divisor_i,
  input  logic [ModWidth-1:0] mult_i,
  output div_stat_t           stat_o,
  output logic [ModWidth-1:0] rem_o,
  output logic [ModWidth-1:0] prod_o
);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [DivWidth-1:0] num_q, num_d;
  logic [ModWidth-1:0] den_q, den_d;
  logic [ModWidth-1:0] mul_q, mul_d;
  logic [ModWidth-1:0] rem_q, rem_d;
  logic [ModWidth-1:0] acc_q, acc_d;

  logic [ModWidth:0]   trial;
  logic [ModWidth:0]   diff;
  logic                ge;
  logic                busy;

  assign busy  = (cnt_q != '0);
  assign trial = {rem_q, num_q[DivWidth-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Step logic: shift in one dividend bit, subtract when it fits
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    den_d  = den_q;
    mul_d  = mul_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (start_i) begin
      cnt_d = CntWidth'(DivWidth);
      num_d = dividend_i;
      den_d = divisor_i;
      mul_d = mult_i;
      rem_d = '0;
      acc_d = '0;
    end else if (busy) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntWidth'(1));
      num_d  = {num_q[DivWidth-2:0], 1'b0};
      rem_d  = ge ? diff[ModWidth-1:0] : trial[ModWidth-1:0];
      acc_d  = {acc_q[ModWidth-2:0], 1'b0} + (ge ? mul_q : '0);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    mul_q <= mul_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;
  assign prod_o      = acc_q;

endmodule

FILE: rtl/core/modular_inverse_euclid.sv
// For a modulus below 2 the sequencer goes straight to the finish state;
// otherwise it runs one division for the exponent reduction plus one per
// Euclid round on the shared bit-serial divider, then loads the result. The
// reduced exponent stays below 2**ExpWidth, so there are at most about 46 rounds.
// One item at a time: input stall is high from acceptance until the result enters
// the output register. Reset clears the sequencer and output valid; there is no
// memory and no clearing pass.
`timescale 1ns / 1ps

module modular_inverse_euclid import mie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mie_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mie_out_t out_data_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StReduce = 2'd1;
  localparam logic [1:0] StLoop   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [ModWidth-1:0] m_q, m_d;
  logic [ModWidth-1:0] rc_q, rc_d;
  logic [ModWidth-1:0] up_q, up_d;
  logic [ModWidth-1:0] uc_q, uc_d;
  logic                pos_q, pos_d;
  logic                none_q, none_d;
  logic                out_valid_q, out_valid_d;
  mie_out_t            out_q, out_d;

  logic                in_acc;
  logic                out_free;
  logic                div_start;
  logic [DivWidth-1:0] div_dividend;
  logic [ModWidth-1:0] div_divisor;
  logic [ModWidth-1:0] div_mult;
  div_stat_t           div_stat;
  logic [ModWidth-1:0] div_rem;
  logic [ModWidth-1:0] div_prod;
  logic [ModWidth-1:0] u_next;
  logic [ModWidth-1:0] mag;
  logic [ModWidth-1:0] inv_fix;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign u_next     = up_q + div_prod;

  // Final fixup: reduce the magnitude and apply the coefficient sign
  assign mag     = (uc_q == m_q) ? '0 : uc_q;
  assign inv_fix = (pos_q || (mag == '0)) ? mag : (m_q - mag);

  // Shared divider
  mie_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .mult_i     (div_mult),
    .stat_o     (div_stat),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    m_d          = m_q;
    rc_d         = rc_q;
    up_d         = up_q;
    uc_d         = uc_q;
    pos_d        = pos_q;
    none_d       = none_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    div_start    = 1'b0;
    div_dividend = DivWidth'(m_q);
    div_divisor  = div_rem;
    div_mult     = u_next;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          m_d    = in_data_i.modulus;
          none_d = 1'b0;
          if (in_data_i.modulus < ModWidth'(2)) begin
            none_d  = 1'b1;
            state_d = StFinish;
          end else begin
            div_start    = 1'b1;
            div_dividend = DivWidth'(in_data_i.exponent);
            div_divisor  = in_data_i.modulus;
            div_mult     = '0;
            state_d      = StReduce;
          end
        end
      end
      StReduce: begin
        if (div_stat.done) begin
          rc_d  = div_rem;
          up_d  = '0;
          uc_d  = ModWidth'(1);
          pos_d = 1'b1;
          if (div_rem == '0) begin
            none_d  = 1'b1;
            state_d = StFinish;
          end else if (div_rem == ModWidth'(1)) begin
            state_d = StFinish;
          end else begin
            // first round: m / r
            div_start    = 1'b1;
            div_dividend = DivWidth'(m_q);
            div_divisor  = div_rem;
            div_mult     = ModWidth'(1);
            state_d      = StLoop;
          end
        end
      end
      StLoop: begin
        if (div_stat.done) begin
          rc_d  = div_rem;
          up_d  = uc_q;
          uc_d  = u_next;
          pos_d = !pos_q;
          if (div_rem == '0) begin
            none_d  = 1'b1;
            state_d = StFinish;
          end else if (div_rem == ModWidth'(1)) begin
            state_d = StFinish;
          end else begin
            // next round: previous remainder / new remainder
            div_start    = 1'b1;
            div_dividend = DivWidth'(rc_q);
            div_divisor  = div_rem;
            div_mult     = u_next;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.no_inverse = none_q;
          out_d.inverse    = none_q ? '0 : inv_fix;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    rc_q   <= rc_d;
    up_q   <= up_d;
    uc_q   <= uc_d;
    pos_q  <= pos_d;
    none_q <= none_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result without an inverse always carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_inverse |-> out_data_o.inverse == '0)
    else $error("no_inverse result with nonzero inverse");

  // The divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StReduce || state_q == StLoop))
    else $error("divider done outside a division state");

  // A division is never started on a busy divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Leaving the finish state always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && out_free |=> out_valid_o && state_q == StIdle)
    else $error("finish did not load the result");

  // A found inverse is below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && !none_q |-> inv_fix < m_q)
    else $error("inverse not reduced");

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for modular_inverse_euclid: a directed table, then random items.
// Checked against typed-in rows or a local extended-Euclid predictor. Depends on mie_pkg.
`timescale 1ns / 1ps

module tb_top;
  import mie_pkg::*;

  // One expected result, kept with the item that caused it for messages
  typedef struct packed {
    mie_in_t  item;
    mie_out_t want;
  } inv_expect_t;

  // Directed row: the expected result is typed in only where known is set
  typedef struct {
    mie_in_t  item;
    bit       known;
    mie_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mie_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mie_out_t out_data;

  inv_expect_t pending_q[$];
  dir_row_t    dir_rows[$];
  int unsigned fails = 0;
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  inv_expect_t oldest;

  modular_inverse_euclid dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #8_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Inverse of the exponent modulo the modulus, or the no-inverse flag.
  // Coefficient magnitudes only; the sign alternates each round.
  function automatic mie_out_t modinv_predict(input mie_in_t item);
    logic [ModWidth:0] m;
    logic [ModWidth:0] r_prev;
    logic [ModWidth:0] r_cur;
    logic [ModWidth:0] r_next;
    logic [ModWidth:0] u_prev;
    logic [ModWidth:0] u_cur;
    logic [ModWidth:0] u_next;
    logic [ModWidth:0] q;
    logic [ModWidth:0] mag;
    logic [ModWidth:0] neg;
    logic              positive;
    mie_out_t          res;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    m = {1'b0, item.modulus};
    if (m < 2) return res;
    r_prev = m;
    r_cur  = item.exponent % m;
    if (r_cur == 0) return res;
    u_prev   = '0;
    u_cur    = (ModWidth+1)'(1);
    positive = 1'b1;
    while (r_cur > 1) begin
      q        = r_prev / r_cur;
      r_next   = r_prev - q * r_cur;
      u_next   = u_prev + q * u_cur;
      r_prev   = r_cur;
      r_cur    = r_next;
      u_prev   = u_cur;
      u_cur    = u_next;
      positive = ~positive;
    end
    if (r_cur != 1) return res;
    mag = u_cur % m;
    neg = m - mag;
    res.inverse    = (positive || mag == 0) ? mag[ModWidth-1:0] : neg[ModWidth-1:0];
    res.no_inverse = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    fails++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  task automatic add_row(input logic [ExpWidth-1:0] e, input logic [ModWidth-1:0] m,
                         input bit known, input logic [ModWidth-1:0] inv, input logic none);
    dir_row_t row;
    row.item.exponent  = e;
    row.item.modulus   = m;
    row.known          = known;
    row.want.inverse   = inv;
    row.want.no_inverse = none;
    dir_rows.push_back(row);
  endtask

  // Offer one item and hold it until accepted, then record what it must give
  task automatic send_item(input mie_in_t item, input mie_out_t want);
    inv_expect_t ent;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ent.item = item;
    ent.want = want;
    pending_q.push_back(ent);
  endtask

  // Random sender idle cycles before the next item
  task automatic idle_gap();
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering until every outstanding result has come back
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall; one long hold-off after the thirtieth result,
  // longer than the slowest item so that the block fills and stalls its input
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, inverse %0d flag %0b",
                                  out_data.inverse, out_data.no_inverse));
      end else begin
        oldest = pending_q.pop_front();
        if (out_data.no_inverse !== oldest.want.no_inverse)
          report_mismatch($sformatf("e=%0d m=%0d no_inverse got %0b want %0b",
                                    oldest.item.exponent, oldest.item.modulus,
                                    out_data.no_inverse, oldest.want.no_inverse));
        if (out_data.inverse !== oldest.want.inverse)
          report_mismatch($sformatf("e=%0d m=%0d inverse got %0d want %0d",
                                    oldest.item.exponent, oldest.item.modulus,
                                    out_data.inverse, oldest.want.inverse));
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && results_seen == 30) begin
      out_stall <= 1'b1;
      hold_left <= 8000;
      hold_used <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  // Stimulus
  initial begin
    int unsigned kind;
    int unsigned g;
    int unsigned phase;
    int unsigned n;
    logic [63:0] wide;
    mie_in_t     item;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    snd_idle     = 10;
    rcv_idle     = 74;

    // Directed: small moduli, zero exponent, reduction to zero, exponent of one,
    // common factors, field extremes, a long Fibonacci chain
    add_row(32'd3, 63'd0, 1, '0, 1'b1);
    add_row(32'd3, 63'd1, 1, '0, 1'b1);
    add_row(32'd0, 63'd0, 1, '0, 1'b1);
    add_row(32'd1, 63'd0, 1, '0, 1'b1);
    add_row(32'hFFFF_FFFF, 63'd1, 1, '0, 1'b1);
    add_row(32'd0, 63'd7, 1, '0, 1'b1);
    add_row(32'd0, 63'h7FFF_FFFF_FFFF_FFFF, 1, '0, 1'b1);
    add_row(32'd1, 63'd2, 1, 63'd1, 1'b0);
    add_row(32'd1, 63'h7FFF_FFFF_FFFF_FFFF, 1, 63'd1, 1'b0);
    add_row(32'd14, 63'd7, 1, '0, 1'b1);
    add_row(32'd65537, 63'd65537, 1, '0, 1'b1);
    add_row(32'd6, 63'd9, 1, '0, 1'b1);
    add_row(32'd2, 63'd4, 1, '0, 1'b1);
    add_row(32'd2, 63'd3, 1, 63'd2, 1'b0);
    add_row(32'd3, 63'd7, 1, 63'd5, 1'b0);
    add_row(32'hFFFF_FFFF, 63'd2, 1, 63'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 63'd3, 1, '0, 1'b1);
    add_row(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 0, '0, 1'b0);
    add_row(32'd65537, 63'h7FFF_FFFF_FFFF_FFFE, 0, '0, 1'b0);
    add_row(32'd5, 63'h7FFF_FFFF_FFFF_FFFF, 0, '0, 1'b0);
    add_row(32'd2971215073, 63'd4807526976, 0, '0, 1'b0);
    add_row(32'd4294967291, 63'd8589934582, 0, '0, 1'b0);
    add_row(32'd196611, 63'd327685, 0, '0, 1'b0);
    add_row(32'h8000_0000, 63'h4000_0000_0000_0001, 0, '0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      idle_gap();
      send_item(dir_rows[i].item,
                dir_rows[i].known ? dir_rows[i].want : modinv_predict(dir_rows[i].item));
    end
    drain_pending();

    // Random: three idling regimes, the sender pausing for all results between them
    for (phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 10 : (phase == 1) ? 74 : 0;
      rcv_idle = (phase == 0) ? 74 : (phase == 1) ? 10 : 0;
      n        = (phase == 0) ? 26 : 25;
      repeat (n) begin
        kind          = $urandom_range(0, 99);
        item.exponent = $urandom;
        item.modulus  = ModWidth'({$urandom, $urandom});
        if (kind < 40) begin
          // full-width random pair
        end else if (kind < 60) begin
          // key-style: common public exponents, even totient
          case ($urandom_range(0, 3))
            0: item.exponent = 32'd3;
            1: item.exponent = 32'd17;
            2: item.exponent = 32'd65537;
            default: item.exponent = $urandom | 32'd1;
          endcase
          item.modulus[0] = 1'b0;
        end else if (kind < 75) begin
          item.modulus = ModWidth'($urandom_range(0, 1000));
        end else if (kind < 88) begin
          // shared factor between exponent and modulus
          g             = $urandom_range(2, 1000);
          item.exponent = g * $urandom_range(1, 1 << 20);
          wide          = 64'(g) * {$urandom_range(0, 255), $urandom};
          item.modulus  = wide[ModWidth-1:0];
        end else begin
          // exponent usually above the modulus
          item.modulus = ModWidth'($urandom_range(2, 32'h7FFF_FFFF));
        end
        idle_gap();
        send_item(item, modinv_predict(item));
      end
      drain_pending();
    end

    repeat (200) @(posedge clk);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mie_pkg.sv
rtl/core/mie_divider.sv
rtl/core/modular_inverse_euclid.sv
dv/tb_top.sv
